### hw/rtl/lock_command_frame_responder_unit_macros.svh
// Assertion macros for the lock command frame responder, used by lcfr_reply_tx.sv.
// In synthesis builds the macros expand to nothing.
`ifndef LOCK_COMMAND_FRAME_RESPONDER_UNIT_MACROS_SVH
`define LOCK_COMMAND_FRAME_RESPONDER_UNIT_MACROS_SVH

`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define LCFR_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("lcfr assertion failed");
// Checked property that also holds during reset.
`define LCFR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("lcfr assertion failed");
`else
`define LCFR_ASSERT(name, clk, rstn, prop)
`define LCFR_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

### hw/rtl/lcfr_pkg.sv
`default_nettype none

package lcfr_pkg;

  // Number of lock channels served; feedback and drive stop at pin 18.
  localparam int unsigned Channels      = 18;
  localparam int unsigned PinCount      = 18;
  localparam int unsigned DriveChannels = (Channels < PinCount) ? Channels : PinCount;
  localparam int unsigned VecBits       = 24;
  localparam int unsigned ReplyMax      = 11;
  localparam int unsigned ReplyLenW     = 4;
  localparam int unsigned CfgIndexW     = 2;

  // Channels that have a real feedback pin and a drive bit.
  localparam logic [VecBits-1:0]  FbMask    = VecBits'((25'd1 << DriveChannels) - 25'd1);
  localparam logic [PinCount-1:0] DriveMask = PinCount'((25'd1 << DriveChannels) - 25'd1);

  localparam logic [7:0] CmdFloor    = 8'h80;
  localparam logic [7:0] StateOn     = 8'h11;
  localparam logic [7:0] ReadAllMark = 8'h33;
  localparam logic [7:0] PolInvert   = 8'h01;

  typedef enum logic [7:0] {
    CmdReadState = 8'h80,
    CmdPulseOne  = 8'h8A,
    CmdSetDrive  = 8'h9A,
    CmdClrDrive  = 8'h9B,
    CmdPulseAll  = 8'h9D,
    CmdChipId    = 8'hDD,
    CmdVersion   = 8'hDE,
    CmdSetPol    = 8'hDF,
    CmdGetPol    = 8'hE1
  } cmd_e;

  typedef enum logic [CfgIndexW-1:0] {
    RegDeviceAddress = 2'd0,
    RegChipId        = 2'd1,
    RegFirmware      = 2'd2
  } cfg_reg_e;

  // One complete reply, first byte in data[0].
  typedef struct packed {
    logic [ReplyMax-1:0][7:0] data;
    logic [ReplyLenW-1:0]     len;
    logic [PinCount-1:0]      drive;
    logic [4:0]               pulse_ch;
    logic                     pulse_all;
  } reply_t;

endpackage

`default_nettype wire

### hw/rtl/lcfr_frame_engine.sv
`default_nettype none

module lcfr_frame_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic [7:0]     rx_byte_i,
  input  wire logic [17:0]    pins_i,
  input  wire logic [7:0]     dev_addr_i,
  input  wire logic [55:0]    chip_id_i,
  input  wire logic [15:0]    fw_ver_i,
  output lcfr_pkg::reply_t    reply_o,
  output logic                reply_valid_o
);
  import lcfr_pkg::*;

  logic [3:0][7:0]      hist_q, hist_d;
  logic [7:0]           pol_q, pol_d;
  logic [PinCount-1:0]  drive_q, drive_d;

  logic [7:0] b0, b1, b2, b3, b4;
  logic [7:0] st, v2, v1, v0;
  logic       frame_match, inv, ch_in_vec, ch_ok, fb;
  logic [4:0] idx;
  logic [VecBits-1:0]  sv;
  logic [PinCount-1:0] ch_bit;
  reply_t rep;

  assign b0 = hist_q[0];
  assign b1 = hist_q[1];
  assign b2 = hist_q[2];
  assign b3 = hist_q[3];
  assign b4 = rx_byte_i;

  // Frame check over the four held bytes and the new one.
  assign frame_match = (b0 >= CmdFloor) && ({1'b0, b1} == ({1'b0, dev_addr_i} + 9'd1)) &&
                       (b4 == (b0 ^ b1 ^ b2 ^ b3));

  // Feedback vector: missing channels read 1, then the polarity inversion.
  assign inv = (pol_q == PolInvert);
  assign sv  = (({6'h3F, pins_i} & FbMask) | ~FbMask) ^ {VecBits{inv}};
  assign v2  = sv[23:16];
  assign v1  = sv[15:8];
  assign v0  = sv[7:0];

  // Single channel feedback and drive bit.
  assign idx       = 5'(b2 - 8'd1);
  assign ch_in_vec = (b2 >= 8'd1) && (b2 <= 8'(VecBits));
  assign fb        = ch_in_vec ? sv[idx] : ~inv;
  assign st        = fb ? StateOn : 8'h00;
  assign ch_ok     = (b2 >= 8'd1) && (b2 <= 8'(DriveChannels));
  assign ch_bit    = ch_ok ? (PinCount'(1) << idx) : '0;

  // Command decode and reply assembly.
  always_comb begin
    rep     = '0;
    hist_d  = {b4, b3, b2, b1};
    pol_d   = pol_q;
    drive_d = drive_q;
    if (frame_match) begin
      hist_d = '0;
      case (cmd_e'(b0))
        CmdPulseOne, CmdSetDrive, CmdClrDrive: begin
          if (cmd_e'(b0) == CmdSetDrive) begin
            drive_d = drive_q | ch_bit;
          end else begin
            drive_d = drive_q & ~ch_bit;
          end
          if (cmd_e'(b0) == CmdPulseOne && ch_ok) begin
            rep.pulse_ch = b2[4:0];
          end
          rep.data[0] = b0;
          rep.data[1] = b1;
          rep.data[2] = b2;
          rep.data[3] = st;
          rep.data[4] = b0 ^ b1 ^ b2 ^ st;
          rep.len     = 4'd5;
        end
        CmdPulseAll: begin
          drive_d       = drive_q & ~DriveMask;
          rep.pulse_all = 1'b1;
          rep.data[0]   = b0;
          rep.data[1]   = b1;
          rep.data[2]   = 8'h00;
          rep.data[3]   = v2;
          rep.data[4]   = v1;
          rep.data[5]   = v0;
          rep.data[6]   = b0 ^ b1 ^ v2 ^ v1 ^ v0;
          rep.len       = 4'd7;
        end
        CmdReadState: begin
          rep.data[0] = b0;
          rep.data[1] = b1;
          if (b2 == 8'h00) begin
            rep.data[2] = v2;
            rep.data[3] = v1;
            rep.data[4] = v0;
            rep.data[5] = ReadAllMark;
            rep.data[6] = b0 ^ b1 ^ v2 ^ v1 ^ v0 ^ ReadAllMark;
            rep.len     = 4'd7;
          end else begin
            rep.data[2] = b2;
            rep.data[3] = st;
            rep.data[4] = b0 ^ b1 ^ b2 ^ st;
            rep.len     = 4'd5;
          end
        end
        CmdChipId: begin
          rep.data[0]  = b0;
          rep.data[1]  = b1;
          rep.data[2]  = b2;
          rep.data[3]  = chip_id_i[55:48];
          rep.data[4]  = chip_id_i[47:40];
          rep.data[5]  = chip_id_i[39:32];
          rep.data[6]  = chip_id_i[31:24];
          rep.data[7]  = chip_id_i[23:16];
          rep.data[8]  = chip_id_i[15:8];
          rep.data[9]  = chip_id_i[7:0];
          rep.data[10] = b0 ^ b1 ^ b2 ^ chip_id_i[55:48] ^ chip_id_i[47:40] ^
                         chip_id_i[39:32] ^ chip_id_i[31:24] ^ chip_id_i[23:16] ^
                         chip_id_i[15:8] ^ chip_id_i[7:0];
          rep.len      = 4'd11;
        end
        CmdVersion: begin
          rep.data[0] = b0;
          rep.data[1] = b1;
          rep.data[2] = fw_ver_i[15:8];
          rep.data[3] = fw_ver_i[7:0];
          rep.data[4] = b0 ^ b1 ^ fw_ver_i[15:8] ^ fw_ver_i[7:0];
          rep.len     = 4'd5;
        end
        CmdSetPol: begin
          pol_d       = b3;
          rep.data[0] = b0;
          rep.data[1] = b1;
          rep.data[2] = StateOn;
          rep.data[3] = StateOn;
          rep.data[4] = b0 ^ b1;
          rep.len     = 4'd5;
        end
        CmdGetPol: begin
          rep.data[0] = b0;
          rep.data[1] = b1;
          rep.data[2] = b2;
          rep.data[3] = pol_q;
          rep.data[4] = b0 ^ b1 ^ b2 ^ pol_q;
          rep.len     = 4'd5;
        end
        default: begin
          rep.len = '0;
        end
      endcase
    end
    rep.drive = drive_d;
  end

  assign reply_o       = rep;
  assign reply_valid_o = accept_i && frame_match && (rep.len != '0);

  // Frame state advances only on an accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      pol_q   <= 8'h01;
      drive_q <= '0;
    end else if (accept_i) begin
      hist_q  <= hist_d;
      pol_q   <= pol_d;
      drive_q <= drive_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/lcfr_reply_tx.sv
`default_nettype none

`include "lock_command_frame_responder_unit_macros.svh"

module lcfr_reply_tx (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  lcfr_pkg::reply_t   reply_i,
  input  wire logic          load_i,
  output logic               free_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // tx_byte [7:0], drive_mask [25:8], pulse_channel [30:26], pulse_all [31]
  output logic [31:0]        m_axis_tdata,
  output logic               m_axis_tlast
);
  import lcfr_pkg::*;

  reply_t               reply_q, reply_d;
  logic                 valid_q, valid_d;
  logic [ReplyLenW-1:0] idx_q, idx_d;
  logic                 is_last, first, take;

  assign is_last = (idx_q == ReplyLenW'(reply_q.len - 4'd1));
  assign first   = (idx_q == '0);
  assign take    = valid_q && m_axis_tready;
  assign free_o  = !valid_q || (m_axis_tready && is_last);

  // Output item: pulse requests ride on the first reply byte only.
  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = is_last;
  assign m_axis_tdata  = {first ? reply_q.pulse_all : 1'b0,
                          first ? reply_q.pulse_ch : 5'd0,
                          reply_q.drive,
                          reply_q.data[idx_q]};

  // Reply buffer and byte pointer.
  always_comb begin
    reply_d = reply_q;
    valid_d = valid_q;
    idx_d   = idx_q;
    if (take) begin
      if (is_last) begin
        valid_d = 1'b0;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
    if (load_i) begin
      reply_d = reply_i;
      valid_d = 1'b1;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reply_q <= reply_d;
  end

  `LCFR_ASSERT(a_load_only_when_free, clk_i, rst_ni, load_i |-> free_o)
  `LCFR_ASSERT(a_load_has_bytes, clk_i, rst_ni, load_i |-> (reply_i.len != '0))
  `LCFR_ASSERT(a_idx_in_reply, clk_i, rst_ni, valid_q |-> (idx_q < reply_q.len))
  `LCFR_ASSERT(a_pulse_first_only, clk_i, rst_ni,
    (valid_q && !first) |-> (m_axis_tdata[31:26] == 6'd0))
  `LCFR_ASSERT(a_drain_ends, clk_i, rst_ni,
    (take && is_last && !load_i) |=> !valid_q)

endmodule

`default_nettype wire

### hw/rtl/lock_command_frame_responder_unit.sv
// Lock command frame responder.
// A reply's first byte is offered in the cycle after the check byte is accepted.
// Throughput: one input item per cycle while no reply is pending; a reply's bytes go
// out one per cycle while m_axis_tready is high; the next item is taken with the last.
// Reset (rst_ni low, asynchronous): byte history and drives clear, polarity code 1,
// configuration registers zero, reply buffer empty.
`default_nettype none

module lock_command_frame_responder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // rx_byte [7:0], feedback_pins [25:8], zero [31:26]
  input  wire logic [31:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tx_byte [7:0], drive_mask [25:8], pulse_channel [30:26], pulse_all [31]
  output logic [31:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [55:0] cfg_data_i
);
  import lcfr_pkg::*;

  logic [7:0]  dev_q;
  logic [55:0] id_q;
  logic [15:0] ver_q;
  logic        accept, reply_valid, free;
  reply_t      reply;

  // Configuration registers, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= '0;
      id_q  <= '0;
      ver_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegDeviceAddress: dev_q <= cfg_data_i[7:0];
        RegChipId:        id_q  <= cfg_data_i;
        RegFirmware:      ver_q <= cfg_data_i[15:0];
        default:          ;
      endcase
    end
  end

  // An item is taken whenever the reply buffer is free or draining its last byte.
  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid && free;

  lcfr_frame_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .rx_byte_i    (s_axis_tdata[7:0]),
    .pins_i       (s_axis_tdata[25:8]),
    .dev_addr_i   (dev_q),
    .chip_id_i    (id_q),
    .fw_ver_i     (ver_q),
    .reply_o      (reply),
    .reply_valid_o(reply_valid)
  );

  lcfr_reply_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reply_i      (reply),
    .load_i       (reply_valid),
    .free_o       (free),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire
